### rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA block cipher package
// Shared widths, constants, register indexes and the control word that
// travels from the round sequencer to the cells.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned RC_W       = 7;
    localparam int unsigned MAX_ROUNDS = 64;
    localparam int unsigned MAX_W      = $clog2(MAX_ROUNDS + 1);
    // round counter holds both the register value and the clamp limit
    localparam int unsigned CNT_W      = (MAX_W > RC_W) ? MAX_W : RC_W;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;
    localparam int unsigned       SHL_AMT   = 4;
    localparam int unsigned       SHR_AMT   = 5;

    // configuration register indexes
    localparam int unsigned IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROUNDS = 3'd4;

    localparam logic [RC_W-1:0] ROUNDS_RESET = 7'd32;

    typedef struct packed {
        logic load;     // take a fresh block into the cells
        logic step;     // apply one half-update in every cell
        logic decrypt;  // subtract the mix rather than add it
        logic capture;  // move the finished block into the output register
    } tea_ctrl_t;

endpackage

### rtl/tea_cell.sv
// ----------------------------------------------------------------------------
// TEA cell
// Holds one 32-bit half of the block and applies one Feistel half-update
// per step, using the word handed over by its neighbour.
// ----------------------------------------------------------------------------
module tea_cell (
    input  logic                        clk,
    input  tea_pkg::tea_ctrl_t          ctrl,
    input  logic [tea_pkg::WORD_W-1:0]  load_word,
    input  logic [tea_pkg::WORD_W-1:0]  neighbour,
    input  logic [tea_pkg::WORD_W-1:0]  sum,
    input  logic [tea_pkg::WORD_W-1:0]  key_a,
    input  logic [tea_pkg::WORD_W-1:0]  key_b,
    output logic [tea_pkg::WORD_W-1:0]  word,
    output logic [tea_pkg::WORD_W-1:0]  word_next
);

    logic [tea_pkg::WORD_W-1:0] word_reg;
    logic [tea_pkg::WORD_W-1:0] mix;

    always_comb
    begin
        mix = ((neighbour << tea_pkg::SHL_AMT) + key_a)
            ^ (neighbour + sum)
            ^ ((neighbour >> tea_pkg::SHR_AMT) + key_b);
        word_next = ctrl.decrypt ? (word_reg - mix) : (word_reg + mix);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            word_reg <= load_word;
        end
        else if (ctrl.step)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

### rtl/tea_seq.sv
// ----------------------------------------------------------------------------
// TEA round sequencer
// Counts rounds, keeps the running sum and runs both handshakes.
// ----------------------------------------------------------------------------
module tea_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        op,
    input  logic [tea_pkg::RC_W-1:0]    round_count,
    input  logic                        out_stall,
    output logic                        in_stall,
    output logic                        out_valid,
    output tea_pkg::tea_ctrl_t          ctrl,
    output logic [tea_pkg::WORD_W-1:0]  sum
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                      state_reg;
    logic [tea_pkg::CNT_W-1:0]   left_reg;
    logic [tea_pkg::WORD_W-1:0]  sum_reg;
    logic                        dec_reg;
    logic                        out_valid_reg;

    logic [tea_pkg::CNT_W-1:0]   rc_ext;
    logic [tea_pkg::CNT_W-1:0]   n_eff;
    logic [tea_pkg::WORD_W-1:0]  start_sum;
    logic                        finish;
    logic                        capture;
    logic                        accept;

    always_comb
    begin
        rc_ext = tea_pkg::CNT_W'(round_count);
        n_eff  = (rc_ext > tea_pkg::CNT_W'(tea_pkg::MAX_ROUNDS))
               ? tea_pkg::CNT_W'(tea_pkg::MAX_ROUNDS) : rc_ext;
        // decrypt starts at delta times the round count, encrypt at delta
        start_sum = op ? tea_pkg::WORD_W'(tea_pkg::TEA_DELTA * tea_pkg::WORD_W'(n_eff))
                       : tea_pkg::TEA_DELTA;
        finish  = (state_reg == ST_RUN) && (left_reg == '0);
        capture = finish && (!out_valid_reg || !out_stall);
        accept  = in_valid && ((state_reg == ST_IDLE) || capture);
    end

    assign in_stall     = !((state_reg == ST_IDLE) || capture);
    assign out_valid    = out_valid_reg;
    assign sum          = sum_reg;
    assign ctrl.load    = accept;
    assign ctrl.step    = (state_reg == ST_RUN) && (left_reg != '0);
    assign ctrl.decrypt = dec_reg;
    assign ctrl.capture = capture;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            sum_reg       <= '0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        left_reg  <= n_eff;
                        sum_reg   <= start_sum;
                        dec_reg   <= op;
                    end
                end
                ST_RUN:
                begin
                    if (left_reg != '0)
                    begin
                        left_reg <= left_reg - 1'b1;
                        sum_reg  <= dec_reg ? (sum_reg - tea_pkg::TEA_DELTA)
                                            : (sum_reg + tea_pkg::TEA_DELTA);
                    end
                    else if (capture)
                    begin
                        if (accept)
                        begin
                            left_reg <= n_eff;
                            sum_reg  <= start_sum;
                            dec_reg  <= op;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/tea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// TEA block cipher, top level
// Configurable-round TEA encrypt/decrypt on one 64-bit block at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write key_word0..3 and round_count through cfg_we,
//   cfg_index and cfg_data while no word is in flight. Reset leaves the key
//   at zero and round_count at 32; a count above 64 runs 64 rounds, a count
//   of zero passes the block through unchanged.
//   Input channel: a word (op, block_first, block_second) is taken at a
//   rising edge with in_valid high and in_stall low. op low encrypts, op
//   high decrypts.
//   Output channel: out_first/out_second are offered with out_valid and
//   held while out_stall is high.
//   Timing: the cells run N effective rounds, and the result then moves into
//   the output register; a new word is taken only while idle or in the
//   cycle its predecessor is captured. The two-cell chain performs one full
//   round per cycle; each round depends on the halves left by the one
//   before, so that loop sets the pace.
//   Stall: the output register parts the two sides, so the next word is
//   taken while a finished result waits; the block then holds its second
//   result in the cells until the output register frees up.
//   Reset: asynchronous, active low; clears control state and the
//   configuration registers, and drops any word in flight.
// ----------------------------------------------------------------------------
module tea_block_cipher_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tea_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [tea_pkg::WORD_W-1:0]  block_first,
    input  logic [tea_pkg::WORD_W-1:0]  block_second,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tea_pkg::WORD_W-1:0]  out_first,
    output logic [tea_pkg::WORD_W-1:0]  out_second
);

    logic [tea_pkg::WORD_W-1:0] key0_reg;
    logic [tea_pkg::WORD_W-1:0] key1_reg;
    logic [tea_pkg::WORD_W-1:0] key2_reg;
    logic [tea_pkg::WORD_W-1:0] key3_reg;
    logic [tea_pkg::RC_W-1:0]   rounds_reg;

    logic [tea_pkg::WORD_W-1:0] out_first_reg;
    logic [tea_pkg::WORD_W-1:0] out_second_reg;

    tea_pkg::tea_ctrl_t         ctrl;
    logic [tea_pkg::WORD_W-1:0] sum;

    // cell 0 always leads the round, cell 1 follows with the updated word
    logic [tea_pkg::WORD_W-1:0] lead_load;
    logic [tea_pkg::WORD_W-1:0] follow_load;
    logic [tea_pkg::WORD_W-1:0] lead_ka;
    logic [tea_pkg::WORD_W-1:0] lead_kb;
    logic [tea_pkg::WORD_W-1:0] follow_ka;
    logic [tea_pkg::WORD_W-1:0] follow_kb;
    logic [tea_pkg::WORD_W-1:0] lead_word;
    logic [tea_pkg::WORD_W-1:0] lead_next;
    logic [tea_pkg::WORD_W-1:0] follow_word;
    logic [tea_pkg::WORD_W-1:0] follow_next;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            rounds_reg <= tea_pkg::ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tea_pkg::REG_KEY0:   key0_reg   <= cfg_data;
                tea_pkg::REG_KEY1:   key1_reg   <= cfg_data;
                tea_pkg::REG_KEY2:   key2_reg   <= cfg_data;
                tea_pkg::REG_KEY3:   key3_reg   <= cfg_data;
                tea_pkg::REG_ROUNDS: rounds_reg <= cfg_data[tea_pkg::RC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Decryption updates the second half first: swap the halves and the
    // key pairs so that cell 0 still leads, and swap back on capture.
    always_comb
    begin
        lead_load   = op ? block_second : block_first;
        follow_load = op ? block_first  : block_second;
        lead_ka     = ctrl.decrypt ? key2_reg : key0_reg;
        lead_kb     = ctrl.decrypt ? key3_reg : key1_reg;
        follow_ka   = ctrl.decrypt ? key0_reg : key2_reg;
        follow_kb   = ctrl.decrypt ? key1_reg : key3_reg;
    end

    tea_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .op          (op),
        .round_count (rounds_reg),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .ctrl        (ctrl),
        .sum         (sum)
    );

    tea_cell u_cell_lead (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_word (lead_load),
        .neighbour (follow_word),
        .sum       (sum),
        .key_a     (lead_ka),
        .key_b     (lead_kb),
        .word      (lead_word),
        .word_next (lead_next)
    );

    tea_cell u_cell_follow (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_word (follow_load),
        .neighbour (lead_next),
        .sum       (sum),
        .key_a     (follow_ka),
        .key_b     (follow_kb),
        .word      (follow_word),
        .word_next (follow_next)
    );

    // Output register: capture the finished halves in block order.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            out_first_reg  <= ctrl.decrypt ? follow_word : lead_word;
            out_second_reg <= ctrl.decrypt ? lead_word   : follow_word;
        end
    end

    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;

endmodule

### rtl/tea_block_cipher_checker.sv
// ----------------------------------------------------------------------------
// TEA block cipher port checker
// Watches the top-level ports for in-flight counts and handshake slips.
// ----------------------------------------------------------------------------
module tea_block_cipher_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tea_pkg::WORD_W-1:0]  out_first,
    input logic [tea_pkg::WORD_W-1:0]  out_second
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    always_comb
    begin
        in_acc       = in_valid && !in_stall;
        out_acc      = out_valid && !out_stall;
        pending_next = pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    // count words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_first) && $stable(out_second))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("result delivered with no word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two words in flight");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> !out_valid)
        else $error("result offered while empty");

    a_capture_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_stall))
        else $error("input stalled in the cycle a result was captured");

endmodule

bind tea_block_cipher_top tea_block_cipher_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_first  (out_first),
    .out_second (out_second)
);
